// ===== src/upd_pkg.sv =====
// Package for the URL percent decoder: character codes, run and status types,
// and hex digit helpers. No dependencies.
`timescale 1ns / 1ps

package upd_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PCT   = 8'h25;

  // Default number of runs the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 4;

  // One run: the 0..3 decoded words caused by one input word.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            str_end;
  } run_t;

  // Front to top: run to push plus escape status.
  typedef struct packed {
    logic push;
    run_t run;
    logic idle;
  } front_st_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_val = v[3:0];
  endfunction

endpackage

// ===== src/upd_front.sv =====
// Front end: tracks escape phase and the held hex digit, classifies each
// accepted input word into a run of decoded words. Uses upd_pkg.
`timescale 1ns / 1ps

module upd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  output upd_pkg::front_st_t st
);
  import upd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HEX1 = 3'b100
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [1:0]      n;
  logic [2:0][7:0] bytes;
  logic            do_plain;
  logic            hex;
  logic [7:0]      plain_byte;

  assign hex        = is_hex(in_byte);
  assign plain_byte = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;

  always_comb begin
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    n         = 2'd0;
    bytes     = '0;
    do_plain  = 1'b0;
    case (phase_r)
      PH_PCT: begin
        if (hex && !in_end) begin
          held_nxt  = in_byte;
          phase_nxt = PH_HEX1;
        end else if (hex) begin
          bytes[0] = CHAR_PCT;
          bytes[1] = in_byte;
          n        = 2'd2;
        end else begin
          bytes[0] = CHAR_PCT;
          n        = 2'd1;
          do_plain = 1'b1;
        end
      end
      PH_HEX1: begin
        if (hex) begin
          bytes[0] = {hex_val(held_r), hex_val(in_byte)};
          n        = 2'd1;
        end else begin
          // broken escape: percent and held digit go out literally
          bytes[0] = CHAR_PCT;
          bytes[1] = held_r;
          n        = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain) begin
      if (in_byte == CHAR_PCT && !in_end) begin
        phase_nxt = PH_PCT;
      end else begin
        case (n)
          2'd0:    bytes[0] = plain_byte;
          2'd1:    bytes[1] = plain_byte;
          default: bytes[2] = plain_byte;
        endcase
        n = n + 2'd1;
      end
    end
    if (in_end) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  assign st.push        = accept && (n != 2'd0);
  assign st.run.cnt     = n;
  assign st.run.bytes   = bytes;
  assign st.run.str_end = in_end;
  assign st.idle        = (phase_r == PH_IDLE);

endmodule

// ===== src/upd_queue.sv =====
// Small run queue between front and back ends, register based.
// Uses upd_pkg for the run type.
`timescale 1ns / 1ps

module upd_queue #(
  parameter int Depth = upd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  upd_pkg::run_t                 wr_run,
  input  logic                          pop,
  output upd_pkg::run_t                 head,
  output logic                          empty,
  output logic                          full,
  output logic [$clog2(Depth+1)-1:0]    count
);
  import upd_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  run_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CntW'(Depth));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];
  assign count   = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_run;
    end
  end

endmodule

// ===== src/upd_back.sv =====
// Back end: walks the head run one word per cycle, while out_stall does not hold it,
// into the output register. Uses upd_pkg for the run type.
`timescale 1ns / 1ps

module upd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  upd_pkg::run_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_string_last
);
  import upd_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       run_last_r, str_last_r;
  logic       load;
  logic       last;
  logic [7:0] sel_byte;

  assign load = !empty && (!valid_r || !out_stall);
  assign last = (idx_r == head.cnt - 2'd1);
  assign pop  = load && last;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      default: sel_byte = head.bytes[2];
    endcase
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r     <= sel_byte;
      run_last_r <= last;
      str_last_r <= last && head.str_end;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_run_last    = run_last_r;
  assign out_string_last = str_last_r;

endmodule

// ===== src/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder: front end, run queue and
// back end. Depends on upd_pkg, upd_front, upd_queue and upd_back.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_stall, in_byte, in_end): one encoded character
//   per word; in_end marks the last character of a string. A word is taken at
//   a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid/out_stall): one decoded character per word.
//   out_run_last flags the last word caused by an input word, out_string_last
//   the final decoded character of a string. '+' decodes to space, '%XX' to
//   the byte spelled, a broken escape passes through literally.
//   An input's first word passes the run queue and the output register before
//   it shows on out_valid. An input that only opens an escape causes no word.
//   Throughput: one input word per cycle while each causes at most one output
//   and the receiver does not stall; the back end sends one word per cycle
//   while not stalled. The run queue (QDepth runs) absorbs the bursts of a
//   broken escape (up to three words); in_stall rises only when it is full.
//   Reset (rst_n low, synchronous): escape phase idle, queue empty, no output.
//   A stalled receiver holds the output word; the front keeps accepting until
//   the queue fills.

module url_percent_decoder #(
  parameter int QDepth = upd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_last
);
  import upd_pkg::*;

  localparam int CntW = $clog2(QDepth + 1);

  front_st_t       fst;
  run_t            head;
  logic            q_empty, q_full, pop;
  logic            accept;
  logic [CntW-1:0] q_count;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  upd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_end  (in_end),
    .st      (fst)
  );

  upd_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fst.push),
    .wr_run (fst.run),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full),
    .count  (q_count)
  );

  upd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (q_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_string_last (out_string_last)
  );

  // string end always closes the run it belongs to
  a_str_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_string_last || out_run_last))
    else $error("string_last without run_last");

  // end of string leaves no escape open
  a_end_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end) |=> fst.idle)
    else $error("escape still open after end of string");

  // empty runs are never queued
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fst.push |-> (fst.run.cnt != 2'd0))
    else $error("empty run pushed");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CntW'(QDepth))
    else $error("queue count past depth");

endmodule
